/* rtl/spm_pkg.sv */
package spm_pkg;

   localparam int MAX_CHANNELS = 4;
   localparam int CHANNELS_DEF = 4;

   localparam int SAMPLE_W   = 24;
   localparam int LEVEL_W    = 16;
   localparam int PAN_W      = 16;
   localparam int WEIGHT_W   = 18;
   localparam int SCALED_W   = 40;
   localparam int PROD_W     = SCALED_W + WEIGHT_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int ROUND_SH   = 31;
   localparam int Q_W        = ACC_W - ROUND_SH;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_CH0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN_CH0   = 3'd4;

   localparam logic [LEVEL_W-1:0]         LEVEL_RESET = 16'd32768;
   localparam logic signed [WEIGHT_W-1:0] UNITY_WT    = 18'sd32768;
   localparam logic signed [ACC_W-1:0]    RND_BIAS    = ACC_W'(64'sd1 <<< (ROUND_SH - 1));
   localparam logic signed [Q_W-1:0]      SAT_MAX     = Q_W'(32'sd8388607);
   localparam logic signed [Q_W-1:0]      SAT_MIN     = Q_W'(-32'sd8388608);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_ch0;
      logic signed [SAMPLE_W-1:0] sample_ch1;
      logic signed [SAMPLE_W-1:0] sample_ch2;
      logic signed [SAMPLE_W-1:0] sample_ch3;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_mix;
      logic signed [SAMPLE_W-1:0] right_mix;
   } rsp_word_type;

   typedef struct packed {
      logic [MAX_CHANNELS-1:0][LEVEL_W-1:0]  level;
      logic [MAX_CHANNELS-1:0][WEIGHT_W-1:0] wt_right;
      logic [MAX_CHANNELS-1:0][WEIGHT_W-1:0] wt_left;
   } cfg_type;

   function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] biased;
      logic signed [Q_W-1:0]   q;
      logic signed [SAMPLE_W-1:0] res;
      biased = acc + RND_BIAS;
      q = Q_W'(biased >>> ROUND_SH);
      if (q > SAT_MAX) begin
         res = SAMPLE_W'(SAT_MAX);
      end else if (q < SAT_MIN) begin
         res = SAMPLE_W'(SAT_MIN);
      end else begin
         res = SAMPLE_W'(q);
      end
      return res;
   endfunction

endpackage

/* rtl/stereo_pan_mixer_unit.sv */
// Stereo pan mixer: folds one frame of mono samples into a left/right pair.
// Input channel req_*: one word carries one signed Q1.23 sample per channel.
// Result channel rsp_*: one word carries the saturated left and right mix.
// Both channels use valid/ready; a word moves when valid and ready are high.
// Configuration port csr_*: index 0..3 write the channel levels (unsigned
// Q1.15), index 4..7 the channel pans (signed Q1.15). Write only while idle.
// The path has four register stages (sample, level multiply, pan-weight
// multiply, sum/round/saturate output register) from the accepting edge to
// rsp_valid. Throughput: one word per cycle unless rsp_ready stalls it.
// When rsp_ready is low the output word holds and the stages in front keep
// filling; req_ready drops only once all four stages hold a word.
// Reset clears every stage valid, sets all levels to unity and all pans to
// centre.
module stereo_pan_mixer_unit
   import spm_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word
);

   cfg_type                         cfg;
   logic                            pipe_valid;
   logic                            pipe_ready;
   logic [CHANNELS-1:0][PROD_W-1:0] prod_left;
   logic [CHANNELS-1:0][PROD_W-1:0] prod_right;

   spm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spm_mult_pipe #(
      .CHANNELS (CHANNELS)
   ) u_mult_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_word    (req_word),
      .cfg        (cfg),
      .out_valid  (pipe_valid),
      .out_ready  (pipe_ready),
      .prod_left  (prod_left),
      .prod_right (prod_right)
   );

   spm_sum_out #(
      .CHANNELS (CHANNELS)
   ) u_sum_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (pipe_valid),
      .in_ready   (pipe_ready),
      .prod_left  (prod_left),
      .prod_right (prod_right),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

/* rtl/spm_csr.sv */
module spm_csr
   import spm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [MAX_CHANNELS-1:0][LEVEL_W-1:0]  level_ff;
   logic [MAX_CHANNELS-1:0][WEIGHT_W-1:0] wt_right_ff;
   logic [MAX_CHANNELS-1:0][WEIGHT_W-1:0] wt_left_ff;
   logic signed [WEIGHT_W-1:0] pan_ext;
   logic signed [WEIGHT_W-1:0] wt_right_in;
   logic signed [WEIGHT_W-1:0] wt_left_in;

   always_comb begin
      pan_ext     = WEIGHT_W'(signed'(csr_wdata[PAN_W-1:0]));
      wt_right_in = UNITY_WT + pan_ext;
      wt_left_in  = UNITY_WT - pan_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            level_ff[i]    <= LEVEL_RESET;
            wt_right_ff[i] <= UNITY_WT;
            wt_left_ff[i]  <= UNITY_WT;
         end
      end else if (csr_wen) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (csr_index == CSR_IDX_W'(int'(CSR_LEVEL_CH0) + i)) begin
               level_ff[i] <= csr_wdata[LEVEL_W-1:0];
            end
            if (csr_index == CSR_IDX_W'(int'(CSR_PAN_CH0) + i)) begin
               wt_right_ff[i] <= wt_right_in;
               wt_left_ff[i]  <= wt_left_in;
            end
         end
      end
   end

   assign cfg.level    = level_ff;
   assign cfg.wt_right = wt_right_ff;
   assign cfg.wt_left  = wt_left_ff;

   for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_chk
      a_wt_sum: assert property (@(posedge clock) disable iff (reset)
         (WEIGHT_W'(wt_right_ff[g] + wt_left_ff[g]) == WEIGHT_W'(2 * int'(UNITY_WT))))
         else $error("pan weights do not sum to unity pair");
   end

endmodule

/* rtl/spm_mult_pipe.sv */
module spm_mult_pipe
   import spm_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
)
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  req_word_type                     in_word,
   input  cfg_type                          cfg,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [CHANNELS-1:0][PROD_W-1:0]  prod_left,
   output logic [CHANNELS-1:0][PROD_W-1:0]  prod_right
);

   logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] smp_all;
   logic [CHANNELS-1:0][SAMPLE_W-1:0]     smp_ff;
   logic [CHANNELS-1:0][SCALED_W-1:0]     scaled_ff;
   logic [CHANNELS-1:0][PROD_W-1:0]       prod_left_ff;
   logic [CHANNELS-1:0][PROD_W-1:0]       prod_right_ff;
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   assign smp_all = {in_word.sample_ch3, in_word.sample_ch2,
                     in_word.sample_ch1, in_word.sample_ch0};

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CHANNELS; i++) begin
         if (en1 && in_valid) begin
            smp_ff[i] <= smp_all[i];
         end
         if (en2 && v1_ff) begin
            scaled_ff[i] <= SCALED_W'(signed'(smp_ff[i]) * signed'({1'b0, cfg.level[i]}));
         end
         if (en3 && v2_ff) begin
            prod_right_ff[i] <= PROD_W'(signed'(scaled_ff[i]) * signed'(cfg.wt_right[i]));
            prod_left_ff[i]  <= PROD_W'(signed'(scaled_ff[i]) * signed'(cfg.wt_left[i]));
         end
      end
   end

   assign out_valid  = v3_ff;
   assign prod_left  = prod_left_ff;
   assign prod_right = prod_right_ff;

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (v1_ff && v2_ff && v3_ff && !out_ready))
      else $error("input stalled with a free stage");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !out_ready) |=> (v3_ff && $stable(prod_left_ff) && $stable(prod_right_ff)))
      else $error("product stage lost a stalled word");

endmodule

/* rtl/spm_sum_out.sv */
module spm_sum_out
   import spm_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
)
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [CHANNELS-1:0][PROD_W-1:0]  prod_left,
   input  logic [CHANNELS-1:0][PROD_W-1:0]  prod_right,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rsp_word_type                     rsp_word
);

   logic signed [ACC_W-1:0] acc_left;
   logic signed [ACC_W-1:0] acc_right;
   logic                    rsp_valid_ff;
   rsp_word_type            rsp_word_ff;

   always_comb begin
      acc_left  = '0;
      acc_right = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         acc_left  = acc_left  + ACC_W'(signed'(prod_left[i]));
         acc_right = acc_right + ACC_W'(signed'(prod_right[i]));
      end
   end

   assign in_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_word_ff.left_mix  <= round_sat(acc_left);
         rsp_word_ff.right_mix <= round_sat(acc_right);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
module tb_top
   import spm_pkg::*;
();

   class pan_mix_tracker;
      logic [LEVEL_W-1:0]        gain [MAX_CHANNELS];
      logic signed [PAN_W-1:0]   pan  [MAX_CHANNELS];
      rsp_word_type              mix_due [$];
      int                        errors;
      int                        checked;
      int                        frames;

      function new();
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            gain[i] = LEVEL_RESET;
            pan[i] = '0;
         end
         errors = 0;
         checked = 0;
         frames = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx < CSR_PAN_CH0) begin
            gain[idx - CSR_LEVEL_CH0] = val;
         end else begin
            pan[idx - CSR_PAN_CH0] = val;
         end
      endfunction

      function logic signed [SAMPLE_W-1:0] round_to_q23(longint acc);
         longint biased;
         longint q;
         biased = acc + (64'sd1 <<< 30);
         q = biased >>> 31;
         if (q > 64'sd8388607) q = 64'sd8388607;
         if (q < -64'sd8388608) q = -64'sd8388608;
         return q[SAMPLE_W-1:0];
      endfunction

      function rsp_word_type mix_frame(req_word_type w);
         longint smp [MAX_CHANNELS];
         longint lvl;
         longint p;
         longint scaled;
         longint acc_l;
         longint acc_r;
         rsp_word_type r;
         smp[0] = w.sample_ch0;
         smp[1] = w.sample_ch1;
         smp[2] = w.sample_ch2;
         smp[3] = w.sample_ch3;
         acc_l = 0;
         acc_r = 0;
         for (int i = 0; i < CHANNELS_DEF; i++) begin
            lvl = longint'(gain[i]);
            p = longint'(pan[i]);
            scaled = smp[i] * lvl;
            acc_r += scaled * (64'sd32768 + p);
            acc_l += scaled * (64'sd32768 - p);
         end
         r.left_mix = round_to_q23(acc_l);
         r.right_mix = round_to_q23(acc_r);
         return r;
      endfunction

      function void note_frame(req_word_type w);
         mix_due = {mix_due, mix_frame(w)};
         frames++;
      endfunction

      task report(string what, logic [SAMPLE_W-1:0] want, logic [SAMPLE_W-1:0] got);
         errors++;
         $display("MISMATCH %s: expected %0d got %0d (t=%0t)",
                  what, $signed(want), $signed(got), $realtime);
      endtask

      task check_mix(rsp_word_type got);
         rsp_word_type want;
         if (mix_due.size() == 0) begin
            report("unexpected word, left", '0, got.left_mix);
         end else begin
            want = mix_due.pop_front();
            checked++;
            if (got.left_mix !== want.left_mix) begin
               report("left_mix", want.left_mix, got.left_mix);
            end
            if (got.right_mix !== want.right_mix) begin
               report("right_mix", want.right_mix, got.right_mix);
            end
         end
      endtask

      function int pending();
         return mix_due.size();
      endfunction
   endclass

   localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;
   localparam logic [PAN_W-1:0] PAN_LEFT  = 16'h8000;
   localparam logic [PAN_W-1:0] PAN_RIGHT = 16'h7FFF;

   logic                  clock;
   logic                  reset;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   req_word_type          req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_word_type          rsp_word;

   pan_mix_tracker mixes;
   bit  valid_up;
   int  send_idle_pct;
   int  rcv_idle_pct;
   int  settings_used;

   stereo_pan_mixer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) mixes.note_frame(req_word);
         if (rsp_valid && rsp_ready) mixes.check_mix(rsp_word);
      end
   end

   function automatic req_word_type mk(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b,
                                       logic signed [SAMPLE_W-1:0] c, logic signed [SAMPLE_W-1:0] d);
      req_word_type w;
      w.sample_ch0 = a;
      w.sample_ch1 = b;
      w.sample_ch2 = c;
      w.sample_ch3 = d;
      return w;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(7))
         0: return S_MAX;
         1: return S_MIN;
         2: return '0;
         3: return -24'sd1;
         4: return SAMPLE_W'($signed(r[8:0]));
         default: return r[SAMPLE_W-1:0];
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_level();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(5))
         0: return '0;
         1: return 16'hFFFF;
         2: return LEVEL_RESET;
         default: return r[CSR_DATA_W-1:0];
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_pan();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(5))
         0: return PAN_LEFT;
         1: return PAN_RIGHT;
         2: return '0;
         default: return r[CSR_DATA_W-1:0];
      endcase
   endfunction

   task automatic send_frame(input req_word_type w);
      req_word <= w;
      if (!valid_up) begin
         req_valid <= 1'b1;
         valid_up = 1'b1;
      end
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   task automatic hold_until_drained();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
      @(posedge clock);
      while (mixes.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      mixes.set_reg(idx, val);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic run_directed();
      send_frame(mk('0, '0, '0, '0));
      send_frame(mk(S_MAX, S_MAX, S_MAX, S_MAX));
      send_frame(mk(S_MIN, S_MIN, S_MIN, S_MIN));
      send_frame(mk(S_MAX, S_MIN, S_MAX, S_MIN));
      send_frame(mk(S_MIN, S_MAX, S_MIN, S_MAX));
      send_frame(mk(-24'sd1, -24'sd1, -24'sd1, -24'sd1));
      send_frame(mk(24'sd1, 24'sd1, 24'sd1, 24'sd1));
      send_frame(mk(S_MAX, '0, '0, '0));
      send_frame(mk('0, S_MIN, '0, '0));
      send_frame(mk('0, '0, S_MAX, '0));
      send_frame(mk('0, '0, '0, S_MIN));
      send_frame(mk(24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA));
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_word = '0;
      rsp_ready = 1'b0;
      valid_up = 1'b0;
      send_idle_pct = 22;
      rcv_idle_pct = 85;
      settings_used = 1;
      mixes = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      hold_until_drained();

      for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
         write_reg(CSR_IDX_W'(CSR_LEVEL_CH0 + ch), 16'hFFFF);
      end
      write_reg(CSR_IDX_W'(CSR_PAN_CH0 + 0), PAN_LEFT);
      write_reg(CSR_IDX_W'(CSR_PAN_CH0 + 1), PAN_RIGHT);
      write_reg(CSR_IDX_W'(CSR_PAN_CH0 + 2), 16'h0000);
      write_reg(CSR_IDX_W'(CSR_PAN_CH0 + 3), 16'hFFFF);
      settings_used++;
      run_directed();

      for (int round = 0; round < 10; round++) begin
         hold_until_drained();
         if (round < 4) begin
            send_idle_pct = 22;
            rcv_idle_pct = 85;
         end else if (round < 7) begin
            send_idle_pct = 85;
            rcv_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            write_reg(CSR_IDX_W'(CSR_LEVEL_CH0 + ch), pick_level());
            write_reg(CSR_IDX_W'(CSR_PAN_CH0 + ch), pick_pan());
         end
         settings_used++;
         for (int k = 0; k < 93; k++) begin
            send_frame(mk(rand_sample(), rand_sample(), rand_sample(), rand_sample()));
         end
      end

      hold_until_drained();
      $display("Mixed %0d frames under %0d register settings, %0d stereo words checked.",
               mixes.frames, settings_used, mixes.checked);
      $display("Covered full-scale and saturating sums, hard left/right pans, zero and max gain.");
      if (mixes.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

/* files.f */
rtl/spm_pkg.sv
rtl/spm_csr.sv
rtl/spm_mult_pipe.sv
rtl/spm_sum_out.sv
rtl/stereo_pan_mixer_unit.sv
tb/tb_top.sv
